[design/lapt_pkg.sv]
// lapt_pkg: shared types, constants and the arctangent table of the lookahead point tracker
// no dependencies; used by lapt_cordic, lapt_datapath, lapt_ctrl and the top level

package lapt_pkg;

  // configuration register layout
  localparam int CFG_BITS     = 15;
  localparam int CFG_SQ_BITS  = 2 * CFG_BITS;
  localparam int CFG_IDX_BITS = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LOOKAHEAD = 1'b0,
    CFG_DEAD      = 1'b1
  } cfg_idx_e;

  // squared reset values of the two ranges (250 mm and 100 mm)
  localparam logic [CFG_SQ_BITS-1:0] LOOKAHEAD_SQ_RST = 30'd62500;
  localparam logic [CFG_SQ_BITS-1:0] DEAD_SQ_RST      = 30'd10000;

  // cordic arithmetic: angle accumulator in units of 2^-30 rad
  localparam int PRESCALE     = 24;
  localparam int CORDIC_STEPS = 32;
  localparam int STEP_BITS    = 5;
  localparam int Z_FRAC       = 30;
  localparam int Z_BITS       = 35;
  localparam int ATAN_BITS    = 30;

  localparam logic signed [Z_BITS-1:0] PI_Q30 = 35'sd3373259426;
  localparam logic [ATAN_BITS-1:0] QUARTER_PI_Q30 = 30'd843314857;

  typedef logic [ATAN_BITS-1:0] atan_entry_t;
  typedef atan_entry_t [CORDIC_STEPS-1:0] atan_tab_t;

  // atan(2^-i) by its power series in units of 2^-62, rounded half up to 2^-30
  function automatic atan_tab_t atan_table();
    atan_tab_t tab;
    longint    sum;
    longint    term;
    longint    rnd;
    int        e;
    tab = '0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) begin
        tab[i] = QUARTER_PI_Q30;
      end else begin
        sum = 0;
        for (int k = 0; (2 * k + 1) * i <= 62; k++) begin
          e    = 62 - (2 * k + 1) * i;
          term = longint'((64'd1 << e) / 64'(2 * k + 1));
          if ((k % 2) == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
        rnd    = (sum + (longint'(1) <<< 31)) >>> 32;
        tab[i] = rnd[ATAN_BITS-1:0];
      end
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = atan_table();

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LAT_START,
    ST_LAT_RUN,
    ST_YAW_START,
    ST_YAW_RUN,
    ST_EMIT
  } ctrl_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take_point;
    logic update;
    logic start_lat;
    logic start_yaw;
    logic store_lat;
    logic load_out;
  } lapt_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic final_pt;
    logic cordic_busy;
    logic out_free;
  } lapt_sts_t;

endpackage

[design/lapt_in_if.sv]
// lapt_in_if: point input channel, valid/ready handshake with one path point as payload
// depends on nothing

interface lapt_in_if #(
  parameter int COORD_BITS = 16
) ();

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         final_point;

  modport source (output valid, output point_x, output point_y, output final_point,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input final_point,
                  output ready);

endinterface

[design/lapt_out_if.sv]
// lapt_out_if: result channel, valid/ready handshake with steering errors and target point
// depends on nothing

interface lapt_out_if #(
  parameter int COORD_BITS      = 16,
  parameter int ANGLE_FRAC_BITS = 13
) ();

  localparam int ANGLE_W = ANGLE_FRAC_BITS + 3;

  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_W-1:0]    lat_err;
  logic signed [ANGLE_W-1:0]    head_err;
  logic signed [COORD_BITS-1:0] target_x;
  logic signed [COORD_BITS-1:0] target_y;

  modport source (output valid, output lat_err, output head_err, output target_x,
                  output target_y, input ready);
  modport sink   (input valid, input lat_err, input head_err, input target_x,
                  input target_y, output ready);

endinterface

[design/lapt_cordic.sv]
// lapt_cordic: iterative vectoring cordic atan2, one rotation step per cycle
// depends on lapt_pkg for the arctangent table and accumulator format

module lapt_cordic #(
  parameter int OPW             = 17,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [OPW-1:0]             y_i,
  input  logic signed [OPW-1:0]             x_i,
  output logic                              busy_o,
  output logic signed [ANGLE_FRAC_BITS+2:0] angle_o
);

  localparam int ANGLE_W = ANGLE_FRAC_BITS + 3;
  localparam int CW      = OPW + lapt_pkg::PRESCALE + 3;
  localparam int SHIFT   = lapt_pkg::Z_FRAC - ANGLE_FRAC_BITS;

  logic signed [CW-1:0]               x_q, y_q;
  logic signed [lapt_pkg::Z_BITS-1:0] z_q;
  logic                               zero_q;
  logic                               busy_q;
  logic [lapt_pkg::STEP_BITS-1:0]     step_q;

  logic                               neg_x;
  logic signed [OPW-1:0]              x_fold, y_fold;
  logic signed [CW-1:0]               xs, ys;
  logic signed [lapt_pkg::Z_BITS-1:0] at;
  logic                               y_pos;
  logic signed [lapt_pkg::Z_BITS-1:0] z_rnd;

  // fold the left half-plane onto the right one
  assign neg_x  = x_i[OPW-1];
  assign x_fold = neg_x ? -x_i : x_i;
  assign y_fold = neg_x ? -y_i : y_i;

  // one micro-rotation
  assign xs    = x_q >>> step_q;
  assign ys    = y_q >>> step_q;
  assign at    = $signed({{(lapt_pkg::Z_BITS - lapt_pkg::ATAN_BITS){1'b0}},
                          lapt_pkg::ATAN_TAB[step_q]});
  assign y_pos = !y_q[CW-1] && (y_q != '0);

  // operand registers and angle accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CW'(x_fold) <<< lapt_pkg::PRESCALE;
      y_q    <= CW'(y_fold) <<< lapt_pkg::PRESCALE;
      zero_q <= (x_i == '0) && (y_i == '0);
      if (neg_x) begin
        z_q <= y_i[OPW-1] ? -lapt_pkg::PI_Q30 : lapt_pkg::PI_Q30;
      end else begin
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (y_pos) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == lapt_pkg::STEP_BITS'(lapt_pkg::CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // round half up to the output scale
  assign z_rnd   = z_q + (lapt_pkg::Z_BITS'(1) <<< (SHIFT - 1));
  assign angle_o = zero_q ? '0 : z_rnd[SHIFT+ANGLE_W-1:SHIFT];
  assign busy_o  = busy_q;

endmodule

[design/lapt_datapath.sv]
// lapt_datapath: range registers, closest and lookahead point tracking, output register
// depends on lapt_pkg and lapt_cordic

module lapt_datapath #(
  parameter int COORD_BITS      = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lapt_pkg::lapt_cmd_t                  cmd_i,
  output lapt_pkg::lapt_sts_t                  sts_o,
  input  logic                                 cfg_we_i,
  input  logic [lapt_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [lapt_pkg::CFG_BITS-1:0]        cfg_wdata_i,
  input  logic signed [COORD_BITS-1:0]         point_x_i,
  input  logic signed [COORD_BITS-1:0]         point_y_i,
  input  logic                                 final_point_i,
  input  logic                                 res_ready_i,
  output logic                                 res_valid_o,
  output logic signed [ANGLE_FRAC_BITS+2:0]    lat_err_o,
  output logic signed [ANGLE_FRAC_BITS+2:0]    head_err_o,
  output logic signed [COORD_BITS-1:0]         target_x_o,
  output logic signed [COORD_BITS-1:0]         target_y_o
);

  localparam int CB      = COORD_BITS;
  localparam int SQW     = 2 * CB;
  localparam int ANGLE_W = ANGLE_FRAC_BITS + 3;
  localparam int OPW     = CB + 1;
  localparam int DW      = (SQW > lapt_pkg::CFG_SQ_BITS) ? SQW : lapt_pkg::CFG_SQ_BITS;

  // squared ranges
  logic [lapt_pkg::CFG_SQ_BITS-1:0] look_sq_q, dead_sq_q;

  // captured point
  logic signed [CB-1:0] pt_x_q, pt_y_q;
  logic                 fin_q;
  logic [SQW-1:0]       sqx_q, sqy_q;

  // tracking state
  logic                 first_pending_q;
  logic [DW-1:0]        best_q;
  logic signed [CB-1:0] closest_x_q, closest_y_q;
  logic                 cand_found_q;
  logic signed [CB-1:0] cand_x_q, cand_y_q;

  // results
  logic signed [ANGLE_W-1:0] lat_q;
  logic                      res_valid_q;
  logic signed [ANGLE_W-1:0] out_lat_q, out_yaw_q;
  logic signed [CB-1:0]      out_tx_q, out_ty_q;

  logic [CB-1:0]         ax, ay;
  logic [DW-1:0]         pt_dsq;
  logic                  far, closer;
  logic signed [CB-1:0]  tgt_x, tgt_y;
  logic                  lat_zero;
  logic                  cordic_start, cordic_busy;
  logic signed [OPW-1:0] op_x, op_y;
  logic signed [ANGLE_W-1:0] angle;

  // range registers hold squares so the per-point compare needs no multiplier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      look_sq_q <= lapt_pkg::LOOKAHEAD_SQ_RST;
      dead_sq_q <= lapt_pkg::DEAD_SQ_RST;
    end else if (cfg_we_i) begin
      unique case (lapt_pkg::cfg_idx_e'(cfg_idx_i))
        lapt_pkg::CFG_LOOKAHEAD: begin
          look_sq_q <= lapt_pkg::CFG_SQ_BITS'(cfg_wdata_i)
                     * lapt_pkg::CFG_SQ_BITS'(cfg_wdata_i);
        end
        lapt_pkg::CFG_DEAD: begin
          dead_sq_q <= lapt_pkg::CFG_SQ_BITS'(cfg_wdata_i)
                     * lapt_pkg::CFG_SQ_BITS'(cfg_wdata_i);
        end
        default: ;
      endcase
    end
  end

  // magnitudes and squares of the incoming point
  assign ax = point_x_i[CB-1] ? (~point_x_i + CB'(1)) : point_x_i;
  assign ay = point_y_i[CB-1] ? (~point_y_i + CB'(1)) : point_y_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_point) begin
      pt_x_q <= point_x_i;
      pt_y_q <= point_y_i;
      sqx_q  <= SQW'(ax) * SQW'(ax);
      sqy_q  <= SQW'(ay) * SQW'(ay);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= 1'b0;
    end else if (cmd_i.take_point) begin
      fin_q <= final_point_i;
    end
  end

  // distance compares
  assign pt_dsq = DW'(sqx_q) + DW'(sqy_q);
  assign far    = pt_dsq >= DW'(look_sq_q);
  assign closer = pt_dsq < best_q;

  // closest point and first far point at or after it
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      if (first_pending_q || closer) begin
        best_q      <= pt_dsq;
        closest_x_q <= pt_x_q;
        closest_y_q <= pt_y_q;
        cand_x_q    <= pt_x_q;
        cand_y_q    <= pt_y_q;
      end else if (!cand_found_q && far) begin
        cand_x_q <= pt_x_q;
        cand_y_q <= pt_y_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_pending_q <= 1'b1;
      cand_found_q    <= 1'b0;
    end else if (cmd_i.load_out) begin
      first_pending_q <= 1'b1;
      cand_found_q    <= 1'b0;
    end else if (cmd_i.update) begin
      if (first_pending_q || closer) begin
        first_pending_q <= 1'b0;
        cand_found_q    <= far;
      end else if (far) begin
        cand_found_q <= 1'b1;
      end
    end
  end

  // target falls back to the final point
  assign tgt_x    = cand_found_q ? cand_x_q : pt_x_q;
  assign tgt_y    = cand_found_q ? cand_y_q : pt_y_q;
  assign lat_zero = best_q < DW'(dead_sq_q);

  // shared angle unit: bearing of closest point, then heading to target
  assign cordic_start = cmd_i.start_lat || cmd_i.start_yaw;
  assign op_x = cmd_i.start_yaw ? (OPW'(tgt_x) - OPW'(closest_x_q)) : OPW'(closest_x_q);
  assign op_y = cmd_i.start_yaw ? (OPW'(tgt_y) - OPW'(closest_y_q)) : OPW'(closest_y_q);

  lapt_cordic #(
    .OPW             (OPW),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .y_i     (op_y),
    .x_i     (op_x),
    .busy_o  (cordic_busy),
    .angle_o (angle)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_lat) begin
      lat_q <= lat_zero ? '0 : angle;
    end
  end

  // output register, reloadable in the cycle its transaction completes
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_lat_q <= lat_q;
      out_yaw_q <= angle;
      out_tx_q  <= tgt_x;
      out_ty_q  <= tgt_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  assign res_valid_o = res_valid_q;
  assign lat_err_o   = out_lat_q;
  assign head_err_o  = out_yaw_q;
  assign target_x_o  = out_tx_q;
  assign target_y_o  = out_ty_q;

  // status to the controller
  assign sts_o.final_pt    = fin_q;
  assign sts_o.cordic_busy = cordic_busy;
  assign sts_o.out_free    = !res_valid_q || res_ready_i;

`ifndef SYNTHESIS
  // a finished segment leaves the tracker cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> first_pending_q && !cand_found_q)
    else $error("tracking state not cleared after segment");

  // a pending result is never overwritten before its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!res_valid_q || res_ready_i))
    else $error("output register overwritten while still full");
`endif

endmodule

[design/lapt_ctrl.sv]
// lapt_ctrl: sequencing state machine of the lookahead point tracker
// depends on lapt_pkg for the state, command and status types

module lapt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lapt_pkg::lapt_sts_t sts_i,
  output lapt_pkg::lapt_cmd_t cmd_o
);

  lapt_pkg::ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lapt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lapt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_point = 1'b1;
          state_d          = lapt_pkg::ST_UPDATE;
        end
      end
      lapt_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = sts_i.final_pt ? lapt_pkg::ST_LAT_START : lapt_pkg::ST_IDLE;
      end
      lapt_pkg::ST_LAT_START: begin
        cmd_o.start_lat = 1'b1;
        state_d         = lapt_pkg::ST_LAT_RUN;
      end
      lapt_pkg::ST_LAT_RUN: begin
        if (!sts_i.cordic_busy) begin
          cmd_o.store_lat = 1'b1;
          state_d         = lapt_pkg::ST_YAW_START;
        end
      end
      lapt_pkg::ST_YAW_START: begin
        cmd_o.start_yaw = 1'b1;
        state_d         = lapt_pkg::ST_YAW_RUN;
      end
      lapt_pkg::ST_YAW_RUN: begin
        if (!sts_i.cordic_busy) begin
          state_d = lapt_pkg::ST_EMIT;
        end
      end
      lapt_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = lapt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lapt_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // an accepted point is folded into the tracker in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == lapt_pkg::ST_UPDATE)
    else $error("accepted point not followed by update");

  // the angle unit is running in the cycle after it is started
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.start_lat || cmd_o.start_yaw) |=> sts_i.cordic_busy)
    else $error("angle unit not busy after start");

  // results only leave once both angles are done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> $past(state_q == lapt_pkg::ST_YAW_RUN)
                       || $past(state_q == lapt_pkg::ST_EMIT))
    else $error("result loaded outside the emit sequence");
`endif

endmodule

[design/lookahead_point_tracker.sv]
// lookahead_point_tracker: top level, pure pursuit closest and lookahead point with atan2 errors
// depends on lapt_pkg, lapt_in_if, lapt_out_if, lapt_ctrl and lapt_datapath
//
//  channel   direction  payload                                          handshake
//  pt_in     in         point_x, point_y, final_point                    valid / ready
//  res_out   out        lat_err, head_err, target_x, target_y            valid / ready
//  cfg       in         cfg_idx_i, cfg_wdata_i                           cfg_we_i
//
// an ordinary point is captured with the squaring multipliers, then the compare and update of
// the tracker follow in the update state. after its update, a final point runs the 32-step
// cordic twice, once per angle, each with its start and finish steps, then its emit step.
// reset clears the tracker and loads the range registers with 250 mm and 100 mm.
// the output register holds one result; a new segment is taken while it waits, and only the
// next final point stalls, in its emit step, until the pending result is taken.

module lookahead_point_tracker #(
  parameter int COORD_BITS      = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lapt_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [lapt_pkg::CFG_BITS-1:0]     cfg_wdata_i,
  lapt_in_if.sink                           pt_in,
  lapt_out_if.source                        res_out
);

  lapt_pkg::lapt_cmd_t cmd;
  lapt_pkg::lapt_sts_t sts;
  logic                in_ready;

  // sequencer
  lapt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pt_in.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign pt_in.ready = in_ready;

  // tracking, angle unit and output register
  lapt_datapath #(
    .COORD_BITS      (COORD_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .point_x_i     (pt_in.point_x),
    .point_y_i     (pt_in.point_y),
    .final_point_i (pt_in.final_point),
    .res_ready_i   (res_out.ready),
    .res_valid_o   (res_out.valid),
    .lat_err_o     (res_out.lat_err),
    .head_err_o    (res_out.head_err),
    .target_x_o    (res_out.target_x),
    .target_y_o    (res_out.target_y)
  );

endmodule
